[design/irc_tok_pkg.sv]
`timescale 1ns / 1ps

package irc_tok_pkg;

	// bytes the tokeniser reacts to
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SP    = 8'd32;
	localparam logic [7:0] CH_BANG  = 8'd33;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;
	localparam logic [7:0] CH_COLON = 8'd58;
	localparam logic [7:0] CH_AT    = 8'd64;

	typedef logic [2:0] kind_t;

	localparam kind_t KIND_NONE   = 3'd0;
	localparam kind_t KIND_NAME   = 3'd1;
	localparam kind_t KIND_CMD    = 3'd2;
	localparam kind_t KIND_MIDDLE = 3'd3;
	localparam kind_t KIND_TRAIL  = 3'd4;

	typedef struct packed {
		logic [7:0] echo_byte;
		kind_t      field_kind;
		logic       field_first;
		logic       line_end;
		logic       message_kept;
	} tag_t;

endpackage

[design/irc_line_tokenizer.sv]
`timescale 1ns / 1ps

// Streaming IRC line tokeniser. Each accepted byte comes back as one result word
// carrying the byte, the message field it belongs to (sender name, command,
// middle or trailing parameter, or none for delimiters and skipped bytes), a flag
// for the first byte of a field, and on the byte that closes a message (a CR,
// or a byte after a numeric command) an end flag with whether a non-empty
// command was seen. One byte is taken per clock cycle unless the output stalls; a
// byte passes an input register, then a result register, with the parse state
// updated between them. Output backpressure stalls the input with no loss.
module irc_line_tokenizer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] echo_byte,
	output logic [2:0] field_kind,
	output logic       field_first,
	output logic       line_end,
	output logic       message_kept
);

	localparam logic [3:0] MODE_LINE   = 4'd0;
	localparam logic [3:0] MODE_NAME   = 4'd1;
	localparam logic [3:0] MODE_HOST   = 4'd2;
	localparam logic [3:0] MODE_PRECMD = 4'd3;
	localparam logic [3:0] MODE_CMD    = 4'd4;
	localparam logic [3:0] MODE_NUM    = 4'd5;
	localparam logic [3:0] MODE_AFTNUM = 4'd6;
	localparam logic [3:0] MODE_PARAMS = 4'd7;
	localparam logic [3:0] MODE_MIDDLE = 4'd8;
	localparam logic [3:0] MODE_TRAIL  = 4'd9;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       valid_s2;
	irc_tok_pkg::tag_t tag_s2;

	logic [3:0] mode_q;
	logic [1:0] digits_q;
	logic       seen_q;
	logic       open_q;

	logic       load_s2;
	logic       adv_s1;

	logic [3:0] n_mode;
	logic [1:0] n_digits;
	logic       n_seen;
	logic       open_eff;
	logic       do_line;
	logic       do_cmd;
	irc_tok_pkg::kind_t kind;
	logic       msg_end;
	logic       msg_kept;
	logic       is_cr;
	logic       is_sp;
	logic       is_digit;

	assign load_s2  = !valid_s2 || out_ready;
	assign adv_s1   = valid_s1 && load_s2;
	assign in_ready = !valid_s1 || load_s2;

	assign is_cr    = byte_s1 == irc_tok_pkg::CH_CR;
	assign is_sp    = byte_s1 == irc_tok_pkg::CH_SP;
	assign is_digit = byte_s1 >= irc_tok_pkg::CH_ZERO && byte_s1 <= irc_tok_pkg::CH_NINE;

	always_comb begin
		n_mode   = mode_q;
		n_digits = digits_q;
		n_seen   = seen_q;
		open_eff = open_q;
		kind     = irc_tok_pkg::KIND_NONE;
		msg_end  = 1'b0;
		msg_kept = 1'b0;
		do_line  = 1'b0;
		do_cmd   = 1'b0;

		unique case (mode_q)
			MODE_NAME: begin
				if (is_cr) begin
					msg_end  = 1'b1;
					msg_kept = seen_q;
					n_seen   = 1'b0;
					n_digits = 2'd0;
					n_mode   = MODE_LINE;
				end else if (is_sp) begin
					n_mode = MODE_PRECMD;
				end else if (byte_s1 == irc_tok_pkg::CH_BANG || byte_s1 == irc_tok_pkg::CH_AT) begin
					n_mode = MODE_HOST;
				end else begin
					kind = irc_tok_pkg::KIND_NAME;
				end
			end
			MODE_HOST: begin
				if (is_sp)
					n_mode = MODE_PRECMD;
			end
			MODE_PRECMD: begin
				if (!is_sp)
					do_cmd = 1'b1;
			end
			MODE_CMD, MODE_MIDDLE: begin
				if (is_cr) begin
					msg_end  = 1'b1;
					msg_kept = seen_q;
					n_seen   = 1'b0;
					n_digits = 2'd0;
					n_mode   = MODE_LINE;
				end else if (is_sp) begin
					n_mode = MODE_PARAMS;
				end else begin
					kind = (mode_q == MODE_CMD) ? irc_tok_pkg::KIND_CMD
						: irc_tok_pkg::KIND_MIDDLE;
				end
			end
			MODE_NUM: begin
				kind = irc_tok_pkg::KIND_CMD;
				if (digits_q == 2'd2) begin
					n_digits = 2'd0;
					n_mode   = MODE_AFTNUM;
				end else begin
					n_digits = digits_q + 2'd1;
				end
			end
			MODE_AFTNUM: begin
				if (is_cr) begin
					msg_end  = 1'b1;
					msg_kept = seen_q;
					n_seen   = 1'b0;
					n_digits = 2'd0;
					n_mode   = MODE_LINE;
				end else if (is_sp) begin
					n_mode = MODE_PARAMS;
				end else begin
					// close the numeric message, byte then opens the next one
					msg_end  = 1'b1;
					msg_kept = seen_q;
					n_seen   = 1'b0;
					n_digits = 2'd0;
					open_eff = 1'b0;
					do_line  = 1'b1;
				end
			end
			MODE_PARAMS: begin
				if (is_cr) begin
					msg_end  = 1'b1;
					msg_kept = seen_q;
					n_seen   = 1'b0;
					n_digits = 2'd0;
					n_mode   = MODE_LINE;
				end else if (byte_s1 == irc_tok_pkg::CH_COLON) begin
					n_mode = MODE_TRAIL;
				end else if (!is_sp) begin
					kind   = irc_tok_pkg::KIND_MIDDLE;
					n_mode = MODE_MIDDLE;
				end
			end
			MODE_TRAIL: begin
				if (is_cr) begin
					msg_end  = 1'b1;
					msg_kept = seen_q;
					n_seen   = 1'b0;
					n_digits = 2'd0;
					n_mode   = MODE_LINE;
				end else begin
					kind = irc_tok_pkg::KIND_TRAIL;
				end
			end
			default: begin
				do_line = 1'b1;
			end
		endcase

		if (do_line) begin
			priority if (is_cr || byte_s1 == irc_tok_pkg::CH_LF) begin
				n_mode = MODE_LINE;
			end else if (byte_s1 == irc_tok_pkg::CH_COLON) begin
				n_seen = 1'b0;
				n_mode = MODE_NAME;
			end else begin
				n_seen = 1'b0;
				do_cmd = 1'b1;
			end
		end

		if (do_cmd) begin
			priority if (is_digit) begin
				kind     = irc_tok_pkg::KIND_CMD;
				n_seen   = 1'b1;
				n_digits = 2'd1;
				n_mode   = MODE_NUM;
			end else if (is_sp) begin
				n_mode = MODE_PARAMS;
			end else if (is_cr) begin
				msg_end  = 1'b1;
				msg_kept = n_seen;
				n_seen   = 1'b0;
				n_digits = 2'd0;
				n_mode   = MODE_LINE;
			end else begin
				kind   = irc_tok_pkg::KIND_CMD;
				n_seen = 1'b1;
				n_mode = MODE_CMD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			mode_q   <= MODE_LINE;
			digits_q <= 2'd0;
			seen_q   <= 1'b0;
			open_q   <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (load_s2)
				valid_s2 <= valid_s1;
			if (adv_s1) begin
				mode_q   <= n_mode;
				digits_q <= n_digits;
				seen_q   <= n_seen;
				open_q   <= kind != irc_tok_pkg::KIND_NONE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			byte_s1 <= data_byte;
		if (adv_s1) begin
			tag_s2.echo_byte    <= byte_s1;
			tag_s2.field_kind   <= kind;
			tag_s2.field_first  <= (kind != irc_tok_pkg::KIND_NONE) && !open_eff;
			tag_s2.line_end     <= msg_end;
			tag_s2.message_kept <= msg_kept;
		end
	end

	assign out_valid    = valid_s2;
	assign echo_byte    = tag_s2.echo_byte;
	assign field_kind   = tag_s2.field_kind;
	assign field_first  = tag_s2.field_first;
	assign line_end     = tag_s2.line_end;
	assign message_kept = tag_s2.message_kept;

	a_digits_only_numeric: assert property (@(posedge clk) disable iff (!arst_n)
		digits_q != 2'd0 |-> mode_q == MODE_NUM)
		else $error("digit count live outside numeric command");

	a_kept_needs_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && message_kept |-> line_end)
		else $error("kept flag without message end");

	a_first_needs_field: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && field_first |-> field_kind != irc_tok_pkg::KIND_NONE)
		else $error("field start on a delimiter");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted word lost at input register");

endmodule
